// ----- hw/rtl/dss_pkg.sv -----
package dss_pkg;

    // Longest separator the match window supports (1 to 8)
    localparam int SEP_MAX = 8;

    // Window fill count, also wide enough to hold SEP_MAX itself
    localparam int FILL_W = $clog2(SEP_MAX + 1);

    // Result queue depth; a flush gives at most SEP_MAX + 1 results
    localparam int RES_MAX = SEP_MAX + 2;
    localparam int CNT_W   = $clog2(RES_MAX + 1);

    // Register file
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_ANY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_LEN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEP_BYTES = 2'd2;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_LIST_END  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

endpackage

// ----- hw/rtl/delimiter_string_splitter.sv -----
// Delimiter string splitter
//
// Input stream: one beat per string byte (tdata = byte, tuser = 0), closed by
// one end-of-string beat (tuser = 1, tdata ignored). Output stream: one beat
// per result; tuser gives the kind (token byte, token end, list end), tdata
// the byte for token bytes and zero otherwise, tlast marks the last result
// caused by one input beat. A beat whose byte is still held as a possible
// separator start causes no output apart from window bytes released ahead of it.
// Configuration is a plain write port (index, data) used while the stream is
// idle: match-any mode, separator length, separator bytes.
// Each accepted beat is evaluated in the accept cycle and its results land in
// a result register queue; the first result is valid in the next cycle.
// The result queue drains one beat per cycle while m_axis_tready is high; an
// input beat causes up to SEP_MAX + 1 results on a flush. Beats that cause
// zero or one result stream at one per cycle while m_axis_tready stays high.
// s_axis_tready is high when the queue is empty or its last result is being taken this cycle.
// A stall on m_axis_tready holds the queue and, once it is non-empty past its
// last entry, back-pressures the input. Reset clears the window, the token
// state, the queue and all configuration registers.
module delimiter_string_splitter
    import dss_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] char_byte
    input  logic                 s_axis_tuser,   // [0] end_of_string
    // Output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [7:0]           m_axis_tdata,   // [7:0] token_byte
    output logic [1:0]           m_axis_tuser,   // [1:0] result_kind
    output logic                 m_axis_tlast,
    // Configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [63:0]          i_cfg_wdata
);

    // Configuration
    logic        r_any;
    logic [3:0]  r_sep_len;
    logic [63:0] r_sep;

    // Match state
    logic [7:0]        r_win [SEP_MAX];
    logic [FILL_W-1:0] r_fill;
    logic              r_has;

    // Result queue, head at entry 0
    t_res             r_buf [RES_MAX];
    logic [CNT_W-1:0] r_cnt;

    // Next values
    logic [7:0]        n_win [SEP_MAX];
    logic [FILL_W-1:0] n_fill;
    logic              n_has;
    t_res              n_buf [RES_MAX];
    logic [CNT_W-1:0]  n_cnt;

    logic              acc;
    logic              pop;
    logic [FILL_W-1:0] len;
    logic [7:0]        sep_b [SEP_MAX];
    logic [7:0]        wv [SEP_MAX];
    logic [FILL_W-1:0] wn;
    logic [SEP_MAX-1:0] cand;
    logic [FILL_W-1:0] k_sel;
    logic              sub_match;
    logic              any_hit;
    logic [FILL_W-1:0] rel_cnt;
    logic [1:0]        n_extra;
    t_res              e0;
    t_res              e1;

    // Handshakes
    assign s_axis_tready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && m_axis_tready);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = (r_cnt != '0);
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tdata  = r_buf[0].data;
    assign m_axis_tuser  = r_buf[0].kind;
    assign m_axis_tlast  = (r_cnt == CNT_W'(1));

    // Effective separator length, saturated at SEP_MAX
    assign len = (r_sep_len > 4'(SEP_MAX)) ? FILL_W'(SEP_MAX) : FILL_W'(r_sep_len);

    // Window with the incoming byte appended
    always_comb begin
        for (int j = 0; j < SEP_MAX; j++) begin
            sep_b[j] = r_sep[8*j +: 8];
            wv[j]    = (FILL_W'(j) < r_fill) ? r_win[j] : s_axis_tdata;
        end
    end
    assign wn = r_fill + FILL_W'(1);

    // Candidate match starts: suffix from k is a non-empty separator prefix
    always_comb begin
        for (int k = 0; k < SEP_MAX; k++) begin
            cand[k] = (FILL_W'(k) < wn) && ((wn - FILL_W'(k)) <= len);
            for (int i = 0; i < SEP_MAX; i++) begin
                if (k + i < SEP_MAX) begin
                    if ((FILL_W'(k + i) < wn) && (wv[k + i] != sep_b[i])) begin
                        cand[k] = 1'b0;
                    end
                end
            end
        end
    end

    // Leftmost candidate; none means the whole window is released
    always_comb begin
        k_sel = wn;
        for (int k = SEP_MAX - 1; k >= 0; k--) begin
            if (cand[k]) begin
                k_sel = FILL_W'(k);
            end
        end
    end
    assign sub_match = (k_sel < wn) && ((wn - k_sel) == len);

    // Any-character hit
    always_comb begin
        any_hit = 1'b0;
        for (int i = 0; i < SEP_MAX; i++) begin
            if ((FILL_W'(i) < len) && (s_axis_tdata == sep_b[i])) begin
                any_hit = 1'b1;
            end
        end
    end

    // Results and next state for the accepted beat
    always_comb begin
        e0      = '{kind: KIND_LIST_END, data: 8'h00};
        e1      = '{kind: KIND_LIST_END, data: 8'h00};
        n_extra = 2'd1;
        rel_cnt = r_fill;
        n_fill  = '0;
        n_has   = 1'b0;
        for (int j = 0; j < SEP_MAX; j++) begin
            n_win[j] = r_win[j];
        end

        if (s_axis_tuser) begin
            // End of string: flush, close a non-empty token, close the list
            if (r_has || (r_fill != '0)) begin
                e0      = '{kind: KIND_TOKEN_END, data: 8'h00};
                n_extra = 2'd2;
            end
        end else if (r_any) begin
            // Pending bytes go out first, then the byte itself is judged
            if (any_hit) begin
                e0 = '{kind: KIND_TOKEN_END, data: 8'h00};
            end else begin
                e0    = '{kind: KIND_BYTE, data: s_axis_tdata};
                n_has = 1'b1;
            end
        end else begin
            rel_cnt = k_sel;
            if (sub_match) begin
                e0 = '{kind: KIND_TOKEN_END, data: 8'h00};
            end else begin
                n_extra = 2'd0;
                n_fill  = wn - k_sel;
                n_has   = r_has || (k_sel != '0);
                for (int k = 0; k < SEP_MAX; k++) begin
                    if (k_sel == FILL_W'(k)) begin
                        for (int j = 0; j + k < SEP_MAX; j++) begin
                            n_win[j] = wv[j + k];
                        end
                    end
                end
            end
        end

        // Released bytes, then the closing results
        for (int p = 0; p < RES_MAX; p++) begin
            if (p < SEP_MAX && (CNT_W'(p) < CNT_W'(rel_cnt))) begin
                n_buf[p] = '{kind: KIND_BYTE, data: wv[(p < SEP_MAX) ? p : 0]};
            end else if (CNT_W'(p) == CNT_W'(rel_cnt)) begin
                n_buf[p] = e0;
            end else begin
                n_buf[p] = e1;
            end
        end
        n_cnt = CNT_W'(rel_cnt) + CNT_W'(n_extra);
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any     <= 1'b0;
            r_sep_len <= '0;
            r_sep     <= '0;
            r_fill    <= '0;
            r_has     <= 1'b0;
            r_cnt     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MATCH_ANY: r_any     <= i_cfg_wdata[0];
                    CFG_SEP_LEN:   r_sep_len <= i_cfg_wdata[3:0];
                    CFG_SEP_BYTES: r_sep     <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (acc) begin
                r_fill <= n_fill;
                r_has  <= n_has;
                r_cnt  <= n_cnt;
            end else if (pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Payload: window bytes and result queue
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_win <= n_win;
            r_buf <= n_buf;
        end else if (pop) begin
            for (int p = 0; p < RES_MAX - 1; p++) begin
                r_buf[p] <= r_buf[p + 1];
            end
        end
    end

    // Checks
    a_fill_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill < FILL_W'(SEP_MAX))
        else $error("match window reached full depth");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RES_MAX))
        else $error("result queue overrun");

    a_any_mode_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (r_any || s_axis_tuser)) |=> (r_fill == '0))
        else $error("window not emptied in any-character mode or on flush");

    a_drain_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && m_axis_tlast && !acc) |=> !m_axis_tvalid)
        else $error("output valid after last result drained");

    a_nonbyte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != KIND_BYTE)) |-> (m_axis_tdata == 8'h00))
        else $error("non-byte result carries data");

endmodule
